/* hdl/mpoc_pkg.sv */
`default_nettype none

package mpoc_pkg;

    localparam logic [2:0] ACT_PBYTE   = 3'd0;
    localparam logic [2:0] ACT_PLEN    = 3'd1;
    localparam logic [2:0] ACT_TEXT    = 3'd2;
    localparam logic [2:0] ACT_READ    = 3'd3;
    localparam logic [2:0] ACT_NEWTEXT = 3'd4;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_PBYTE,
        OP_PLEN,
        OP_TEXT,
        OP_READ,
        OP_CLEAR
    } t_op;

    typedef struct packed {
        t_op        op;
        logic [4:0] slot;
        logic [3:0] pos;
        logic [7:0] data;
        logic [4:0] len;
    } t_cmd;

    typedef struct packed {
        logic [31:0] count;
        logic [31:0] mask;
    } t_result;

endpackage

`default_nettype wire

/* hdl/mpoc_fifo.sv */
`default_nettype none

module mpoc_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire logic [WIDTH-1:0] i_data,
    output logic                  o_full,
    input  wire logic             i_pop,
    output logic [WIDTH-1:0]      o_data,
    output logic                  o_empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wr_ptr;
    logic [AW-1:0]    r_rd_ptr;
    logic [CW-1:0]    r_count;
    logic             do_push;
    logic             do_pop;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_data  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == AW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == AW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

/* hdl/mpoc_front.sv */
`default_nettype none

module mpoc_front
    import mpoc_pkg::*;
#(
    parameter int NUM_PATTERNS    = 32,
    parameter int MAX_PATTERN_LEN = 16
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_push,
    output logic            o_full,
    input  wire logic [2:0] i_action,
    input  wire logic [4:0] i_pattern_slot,
    input  wire logic [3:0] i_char_position,
    input  wire logic [7:0] i_byte_value,
    input  wire logic [4:0] i_length_value,
    output logic            o_cmd_valid,
    output t_cmd            o_cmd,
    input  wire logic       i_cmd_pop
);

    t_cmd cmd;
    logic slot_ok;
    logic pos_ok;
    logic cmd_empty;
    logic [$bits(t_cmd)-1:0] cmd_bits;

    assign slot_ok = (int'(i_pattern_slot) < NUM_PATTERNS);
    assign pos_ok  = (int'(i_char_position) < MAX_PATTERN_LEN);

    // classify the beat; out-of-range writes and reads become no-op commands here
    always_comb begin
        cmd.slot = i_pattern_slot;
        cmd.pos  = i_char_position;
        cmd.data = i_byte_value;
        cmd.len  = i_length_value;
        if (int'(i_length_value) > MAX_PATTERN_LEN) begin
            cmd.len = 5'(MAX_PATTERN_LEN);
        end
        case (i_action)
            ACT_PBYTE:   cmd.op = (slot_ok && pos_ok) ? OP_PBYTE : OP_NONE;
            ACT_PLEN:    cmd.op = slot_ok ? OP_PLEN : OP_NONE;
            ACT_TEXT:    cmd.op = OP_TEXT;
            ACT_READ:    cmd.op = slot_ok ? OP_READ : OP_NONE;
            ACT_NEWTEXT: cmd.op = OP_CLEAR;
            default:     cmd.op = OP_NONE;
        endcase
    end

    mpoc_fifo #(
        .WIDTH($bits(t_cmd)),
        .DEPTH(2)
    ) u_cmd_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (i_push),
        .i_data  (cmd),
        .o_full  (o_full),
        .i_pop   (i_cmd_pop),
        .o_data  (cmd_bits),
        .o_empty (cmd_empty)
    );

    assign o_cmd       = t_cmd'(cmd_bits);
    assign o_cmd_valid = !cmd_empty;

endmodule

`default_nettype wire

/* hdl/mpoc_back.sv */
`default_nettype none

module mpoc_back
    import mpoc_pkg::*;
#(
    parameter int NUM_PATTERNS    = 32,
    parameter int MAX_PATTERN_LEN = 16,
    parameter int COUNT_WIDTH     = 32
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_cmd_valid,
    input  wire t_cmd i_cmd,
    output logic      o_cmd_pop,
    output logic      o_res_push,
    output t_result   o_res,
    input  wire logic i_res_full
);

    localparam int PW   = (NUM_PATTERNS > 1) ? $clog2(NUM_PATTERNS) : 1;
    localparam int LW   = (MAX_PATTERN_LEN > 1) ? $clog2(MAX_PATTERN_LEN) : 1;
    localparam int LENW = $clog2(MAX_PATTERN_LEN + 1);
    localparam int MW   = (NUM_PATTERNS < 32) ? NUM_PATTERNS : 32;

    logic [7:0]             r_pat [NUM_PATTERNS][MAX_PATTERN_LEN];
    logic [LENW-1:0]        r_len [NUM_PATTERNS];
    logic [7:0]             r_win [MAX_PATTERN_LEN];
    logic [LENW-1:0]        r_fill;
    logic [COUNT_WIDTH-1:0] r_cnt [NUM_PATTERNS];

    logic                    r_s1_valid;
    t_op                     r_s1_op;
    logic [PW-1:0]           r_s1_slot;
    logic [NUM_PATTERNS-1:0] r_s1_match;

    logic [7:0]              n_win [MAX_PATTERN_LEN];
    logic [LENW-1:0]         n_fill;
    logic [NUM_PATTERNS-1:0] match;
    logic                    s1_ready;
    logic                    adv2;
    logic [PW-1:0]           cmd_slot;
    logic [LW-1:0]           cmd_pos;

    assign s1_ready  = !r_s1_valid || !i_res_full;
    assign o_cmd_pop = i_cmd_valid && s1_ready;
    assign adv2      = r_s1_valid && !i_res_full;
    assign cmd_slot  = PW'(i_cmd.slot);
    assign cmd_pos   = LW'(i_cmd.pos);

    // window after this beat's byte shifts in
    always_comb begin
        n_win[0] = i_cmd.data;
        for (int i = 1; i < MAX_PATTERN_LEN; i++) begin
            n_win[i] = r_win[i-1];
        end
        n_fill = (r_fill < LENW'(MAX_PATTERN_LEN)) ? r_fill + 1'b1 : r_fill;
    end

    always_comb begin
        for (int p = 0; p < NUM_PATTERNS; p++) begin
            match[p] = (r_len[p] != '0) && (r_len[p] <= n_fill);
            for (int k = 0; k < MAX_PATTERN_LEN; k++) begin
                if (k < int'(r_len[p])) begin
                    if (r_pat[p][k] != n_win[LW'(int'(r_len[p]) - 1 - k)]) begin
                        match[p] = 1'b0;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int p = 0; p < NUM_PATTERNS; p++) begin
                r_len[p] <= '0;
                for (int k = 0; k < MAX_PATTERN_LEN; k++) begin
                    r_pat[p][k] <= '0;
                end
            end
            for (int i = 0; i < MAX_PATTERN_LEN; i++) begin
                r_win[i] <= '0;
            end
            r_fill     <= '0;
            r_s1_valid <= 1'b0;
            r_s1_op    <= OP_NONE;
            r_s1_slot  <= '0;
            r_s1_match <= '0;
        end else begin
            if (o_cmd_pop) begin
                case (i_cmd.op)
                    OP_PBYTE: r_pat[cmd_slot][cmd_pos] <= i_cmd.data;
                    OP_PLEN:  r_len[cmd_slot] <= LENW'(i_cmd.len);
                    OP_TEXT: begin
                        r_win  <= n_win;
                        r_fill <= n_fill;
                    end
                    OP_CLEAR: begin
                        for (int i = 0; i < MAX_PATTERN_LEN; i++) begin
                            r_win[i] <= '0;
                        end
                        r_fill <= '0;
                    end
                    default: ;
                endcase
            end
            if (s1_ready) begin
                r_s1_valid <= o_cmd_pop;
                r_s1_op    <= i_cmd.op;
                r_s1_slot  <= cmd_slot;
                r_s1_match <= (i_cmd.op == OP_TEXT) ? match : '0;
            end
        end
    end

    // counters update in beat order behind the compare stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int p = 0; p < NUM_PATTERNS; p++) begin
                r_cnt[p] <= '0;
            end
        end else if (adv2) begin
            case (r_s1_op)
                OP_TEXT: begin
                    for (int p = 0; p < NUM_PATTERNS; p++) begin
                        if (r_s1_match[p] && (r_cnt[p] != '1)) begin
                            r_cnt[p] <= r_cnt[p] + 1'b1;
                        end
                    end
                end
                OP_CLEAR: begin
                    for (int p = 0; p < NUM_PATTERNS; p++) begin
                        r_cnt[p] <= '0;
                    end
                end
                default: ;
            endcase
        end
    end

    assign o_res_push = adv2;
    assign o_res = '{
        count: (r_s1_op == OP_READ) ? 32'(r_cnt[r_s1_slot]) : 32'd0,
        mask:  32'(r_s1_match[MW-1:0])
    };

endmodule

`default_nettype wire

/* hdl/multi_pattern_overlap_counter.sv */
// A result reaches the output ports via the compare register and the result queue.
// Throughput: one beat per cycle if no queue is full; all patterns check the window.
// The command queue and result queue (two entries each) decouple the two sides.
// Reset (synchronous, active low) clears patterns, lengths, window, fill, counters
// and both queues.
`default_nettype none

module multi_pattern_overlap_counter
    import mpoc_pkg::*;
#(
    parameter int NUM_PATTERNS    = 32,
    parameter int MAX_PATTERN_LEN = 16,
    parameter int COUNT_WIDTH     = 32
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        push,
    output logic             full,
    input  wire logic [2:0]  i_action,
    input  wire logic [4:0]  i_pattern_slot,
    input  wire logic [3:0]  i_char_position,
    input  wire logic [7:0]  i_byte_value,
    input  wire logic [4:0]  i_length_value,
    output logic             empty,
    input  wire logic        pop,
    output logic [31:0]      o_count_value,
    output logic [31:0]      o_match_mask
);

    logic    cmd_valid;
    t_cmd    cmd;
    logic    cmd_pop;
    logic    res_push;
    t_result res;
    logic    res_full;
    logic [$bits(t_result)-1:0] res_bits;
    t_result res_head;

    mpoc_front #(
        .NUM_PATTERNS    (NUM_PATTERNS),
        .MAX_PATTERN_LEN (MAX_PATTERN_LEN)
    ) u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_push          (push),
        .o_full          (full),
        .i_action        (i_action),
        .i_pattern_slot  (i_pattern_slot),
        .i_char_position (i_char_position),
        .i_byte_value    (i_byte_value),
        .i_length_value  (i_length_value),
        .o_cmd_valid     (cmd_valid),
        .o_cmd           (cmd),
        .i_cmd_pop       (cmd_pop)
    );

    mpoc_back #(
        .NUM_PATTERNS    (NUM_PATTERNS),
        .MAX_PATTERN_LEN (MAX_PATTERN_LEN),
        .COUNT_WIDTH     (COUNT_WIDTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (cmd_valid),
        .i_cmd       (cmd),
        .o_cmd_pop   (cmd_pop),
        .o_res_push  (res_push),
        .o_res       (res),
        .i_res_full  (res_full)
    );

    mpoc_fifo #(
        .WIDTH($bits(t_result)),
        .DEPTH(2)
    ) u_res_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_push),
        .i_data  (res),
        .o_full  (res_full),
        .i_pop   (pop),
        .o_data  (res_bits),
        .o_empty (empty)
    );

    assign res_head      = t_result'(res_bits);
    assign o_count_value = res_head.count;
    assign o_match_mask  = res_head.mask;

endmodule

`default_nettype wire
